>>> hdl/png_row_unfilter_top_defines.svh
// Assertion macros for the PNG row unfilter top level.
`ifndef PNG_ROW_UNFILTER_TOP_DEFINES_SVH
`define PNG_ROW_UNFILTER_TOP_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold too.
`define PRU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the cycle after.
`define PRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/pru_pkg.sv
// Types, codes and helpers for the PNG row unfilter.
package pru_pkg;

	localparam int unsigned DEF_MAX_ROW_BYTES = 8192;
	localparam int unsigned DEF_MAX_ROWS      = 8192;

	localparam int unsigned CFG_DIM_W = 14;
	localparam int unsigned CFG_BPP_W = 3;
	// product of width and bytes per pixel, and room for limits up to 65536
	localparam int unsigned ROW_BYTES_W = 17;
	localparam int unsigned PADDR_W     = 4;
	localparam int unsigned PDATA_W     = 32;
	localparam logic [CFG_BPP_W-1:0] BPP_MAX = 3'd4;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_FILTER = 3'd1,
		ST_SHORT      = 3'd2,
		ST_LONG       = 3'd3,
		ST_WIDE       = 3'd4
	} pru_status_t;

	typedef enum logic [2:0] {
		FT_NONE  = 3'd0,
		FT_SUB   = 3'd1,
		FT_UP    = 3'd2,
		FT_AVG   = 3'd3,
		FT_PAETH = 3'd4
	} pru_filter_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BPP    = 2'd2
	} pru_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} pru_item_t;

	typedef struct packed {
		logic [7:0]  pixel_byte;
		logic        pixel_valid;
		pru_status_t status;
		logic        last_result;
	} pru_res_t;

	// Per-item decisions made at accept time, carried into the datapath stage.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last;
		logic        emit;
		logic        do_px;
		logic        valid;
		pru_status_t status;
		pru_filter_t ftype;
		logic        row_nz;
		logic        has_left;
		logic [1:0]  hidx;
		logic [1:0]  widx;
	} pru_op_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		logic [7:0] r;
		// pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = da + db;
		pa = da[9] ? 10'(-da) : 10'(da);
		pb = db[9] ? 10'(-db) : 10'(db);
		pc = dc[9] ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) r = a;
		else if (pb <= pc) r = b;
		else r = c;
		return r;
	endfunction

endpackage

>>> hdl/pru_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface pru_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/pru_ctrl.sv
// Row/column tracking, filter type and error status decided at accept time.
module pru_ctrl #(
	parameter int unsigned MAX_ROW_BYTES = pru_pkg::DEF_MAX_ROW_BYTES,
	parameter int unsigned MAX_ROWS      = pru_pkg::DEF_MAX_ROWS,
	localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            acc,
	input  pru_pkg::pru_item_t              item,
	input  logic [pru_pkg::CFG_DIM_W-1:0]   width_pixels,
	input  logic [pru_pkg::CFG_DIM_W-1:0]   height_rows,
	input  logic [pru_pkg::CFG_BPP_W-1:0]   bpp_cfg,
	output pru_pkg::pru_op_t                op,
	output logic [AW-1:0]                   rd_addr
);
	import pru_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ROW_BYTES + 1);
	localparam int unsigned RW = $clog2(MAX_ROWS + 1);
	localparam logic [ROW_BYTES_W-1:0] MaxRb = ROW_BYTES_W'(MAX_ROW_BYTES);
	localparam logic [ROW_BYTES_W-1:0] MaxRows = ROW_BYTES_W'(MAX_ROWS);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	pru_filter_t   ft_q;
	pru_status_t   err_q;

	logic [CW-1:0] col_n;
	logic [RW-1:0] row_n;
	pru_filter_t   ft_n;
	pru_status_t   err_in;
	pru_status_t   err_n;

	logic [CFG_BPP_W-1:0]   bpp;
	logic [CFG_DIM_W-1:0]   wpx;
	logic [ROW_BYTES_W-1:0] rb;
	logic [ROW_BYTES_W-1:0] hh;
	logic [ROW_BYTES_W-1:0] hraw;
	logic [CW-1:0]          x;

	// register ranges: zero reads as one, bpp and height saturate at their limits
	always_comb begin
		bpp = bpp_cfg;
		if (bpp == '0) bpp = CFG_BPP_W'(1);
		else if (bpp > BPP_MAX) bpp = BPP_MAX;
		wpx = (width_pixels == '0) ? CFG_DIM_W'(1) : width_pixels;
		rb  = ROW_BYTES_W'(wpx) * ROW_BYTES_W'(bpp);
		hraw = (height_rows == '0) ? ROW_BYTES_W'(1) : ROW_BYTES_W'(height_rows);
		hh  = (hraw > MaxRows) ? MaxRows : hraw;
	end

	assign x       = col_q - CW'(1);
	assign rd_addr = AW'(x);

	always_comb begin
		err_in = err_q;
		if (err_q == ST_OK && rb > MaxRb) err_in = ST_WIDE;
		err_n = err_in;
		col_n = col_q;
		row_n = row_q;
		ft_n  = ft_q;

		op           = '0;
		op.data_byte = item.data_byte;
		op.last      = item.last_byte;
		op.ftype     = ft_q;
		op.row_nz    = (row_q != '0);
		op.has_left  = (ROW_BYTES_W'(x) >= ROW_BYTES_W'(bpp));
		op.hidx      = 2'(x) - 2'(bpp);
		op.widx      = 2'(x);

		if (err_in == ST_WIDE) begin
			op.emit = 1'b1;
		end else if (ROW_BYTES_W'(row_q) >= hh) begin
			if (err_in == ST_OK) err_n = ST_LONG;
			op.emit = 1'b1;
		end else if (col_q == '0) begin
			if (item.data_byte > 8'(FT_PAETH)) begin
				if (err_in == ST_OK) err_n = ST_BAD_FILTER;
				ft_n = FT_NONE;
			end else begin
				ft_n = pru_filter_t'(item.data_byte[2:0]);
			end
			col_n   = CW'(1);
			op.emit = (err_n != ST_OK);
		end else begin
			op.do_px = 1'b1;
			op.valid = (err_in == ST_OK);
			op.emit  = 1'b1;
			if (ROW_BYTES_W'(col_q) >= rb) begin
				col_n = '0;
				row_n = row_q + RW'(1);
			end else begin
				col_n = col_q + CW'(1);
			end
		end

		if (item.last_byte) begin
			if (err_n == ST_OK && ROW_BYTES_W'(row_n) < hh) err_n = ST_SHORT;
			op.emit = 1'b1;
		end
		op.status = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ft_q  <= FT_NONE;
			err_q <= ST_OK;
		end else if (acc) begin
			if (item.last_byte) begin
				col_q <= '0;
				row_q <= '0;
				ft_q  <= FT_NONE;
				err_q <= ST_OK;
			end else begin
				col_q <= col_n;
				row_q <= row_n;
				ft_q  <= ft_n;
				err_q <= err_n;
			end
		end
	end

endmodule

>>> hdl/pru_recon.sv
// Line store, neighbor histories and the filter reconstruction stage.
module pru_recon #(
	parameter int unsigned MAX_ROW_BYTES = pru_pkg::DEF_MAX_ROW_BYTES,
	localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  pru_pkg::pru_op_t  op,
	input  logic [AW-1:0]     rd_addr,
	input  logic              adv,
	output logic              busy,
	output logic              emit,
	output pru_pkg::pru_res_t res
);
	import pru_pkg::*;

	logic [7:0] mem [MAX_ROW_BYTES];
	logic [7:0] rd_q;

	logic          v_s1;
	pru_op_t       op_s1;
	logic [AW-1:0] x_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_d_s1;

	logic [7:0] lh_q [4];
	logic [7:0] uh_q [4];

	logic [7:0] left;
	logic [7:0] up;
	logic [7:0] upleft;
	logic [7:0] pred;
	logic [7:0] rec;
	logic       wr;

	assign wr = adv && v_s1 && op_s1.do_px;

	// line store: one write (retiring item) and one read (entering item) per cycle
	always_ff @(posedge clk) begin
		if (wr) mem[x_s1] <= rec;
		if (acc) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1    <= op;
			x_s1     <= rd_addr;
			// same-entry read during write returns old data: bypass it
			fwd_s1   <= wr && (rd_addr == x_s1);
			fwd_d_s1 <= rec;
		end
	end

	always_comb begin
		left   = op_s1.has_left ? lh_q[op_s1.hidx] : 8'd0;
		up     = op_s1.row_nz ? (fwd_s1 ? fwd_d_s1 : rd_q) : 8'd0;
		upleft = (op_s1.row_nz && op_s1.has_left) ? uh_q[op_s1.hidx] : 8'd0;
		case (op_s1.ftype)
			FT_SUB:   pred = left;
			FT_UP:    pred = up;
			FT_AVG:   pred = 8'((9'(left) + 9'(up)) >> 1);
			FT_PAETH: pred = paeth(left, up, upleft);
			default:  pred = 8'd0;
		endcase
		rec = op_s1.data_byte + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				lh_q[i] <= '0;
				uh_q[i] <= '0;
			end
		end else if (adv && v_s1) begin
			if (op_s1.last) begin
				for (int i = 0; i < 4; i++) begin
					lh_q[i] <= '0;
					uh_q[i] <= '0;
				end
			end else if (op_s1.do_px) begin
				lh_q[op_s1.widx] <= rec;
				uh_q[op_s1.widx] <= up;
			end
		end
	end

	assign busy            = v_s1;
	assign emit            = v_s1 && op_s1.emit;
	assign res.pixel_byte  = op_s1.valid ? rec : 8'd0;
	assign res.pixel_valid = op_s1.valid;
	assign res.status      = op_s1.status;
	assign res.last_result = op_s1.last;

endmodule

>>> hdl/png_row_unfilter_top.sv
// Top level of the PNG row unfilter: config port, pipeline glue, output register.
//
//  channel   dir  handshake          payload
//  feed      in   valid/ready        data_byte[7:0], last_byte
//  result    out  valid/ready        pixel_byte[7:0], pixel_valid, status[2:0], last_result
//  apb       in   psel/penable/pwr   paddr[3:0], pwdata[31:0] -> prdata[31:0]
//
// One item per cycle sustained unless result.ready stalls the output. Accept cycle:
// positions, filter type and status are settled and the line store is read; next
// cycle the predictor runs, and the line store and histories are written when the
// stage advances. A write and a read of the same entry in one edge are bypassed.
// Reset clears positions, status, histories and registers (width 1, height 1,
// 4 bytes per pixel); the line store is not cleared, row 0 never uses it.
// result.ready low stalls the output register, then the reconstruction stage,
// then feed.ready; an item with no result leaves without touching the output.
`include "png_row_unfilter_top_defines.svh"

module png_row_unfilter_top #(
	parameter int unsigned MAX_ROW_BYTES = pru_pkg::DEF_MAX_ROW_BYTES,
	parameter int unsigned MAX_ROWS      = pru_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pru_stream_if.sink                    feed,
	pru_stream_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pru_pkg::PADDR_W-1:0]   paddr,
	input  logic [pru_pkg::PDATA_W-1:0]   pwdata,
	output logic [pru_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import pru_pkg::*;

	localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

	// configuration registers
	logic [CFG_DIM_W-1:0] width_q;
	logic [CFG_DIM_W-1:0] height_q;
	logic [CFG_BPP_W-1:0] bpp_q;
	logic                 cfg_wr;
	pru_reg_t             reg_sel;

	// pipeline
	logic      acc;
	logic      adv;
	logic      s1_busy;
	logic      s1_emit;
	pru_op_t   op;
	logic [AW-1:0] rd_addr;
	pru_res_t  s1_res;
	pru_item_t item;

	logic     out_v_q;
	pru_res_t out_d_q;

	// check terms
	logic out_blocked;
	logic mid_pix;

	// --- APB: zero-wait writes in the access phase, combinational read-back
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = pru_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DIM_W'(1);
			height_q <= CFG_DIM_W'(1);
			bpp_q    <= BPP_MAX;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[CFG_DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_DIM_W-1:0];
				REG_BPP:    bpp_q    <= pwdata[CFG_BPP_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_BPP:    prdata = PDATA_W'(bpp_q);
			default:    prdata = '0;
		endcase
	end

	// --- handshake: the stage moves on unless it holds a result that cannot
	// enter a full, stalled output register
	assign adv        = !s1_busy || !s1_emit || !out_v_q || result.ready;
	assign feed.ready = !s1_busy || adv;
	assign acc        = feed.valid && feed.ready;
	assign item       = feed.data;

	pru_ctrl #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.MAX_ROWS(MAX_ROWS)
	) u_ctrl (
		.clk,
		.arst_n,
		.acc,
		.item,
		.width_pixels(width_q),
		.height_rows(height_q),
		.bpp_cfg(bpp_q),
		.op,
		.rd_addr
	);

	pru_recon #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_recon (
		.clk,
		.arst_n,
		.acc,
		.op,
		.rd_addr,
		.adv,
		.busy(s1_busy),
		.emit(s1_emit),
		.res(s1_res)
	);

	// --- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && s1_emit) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_emit) out_d_q <= s1_res;
	end

	assign result.valid = out_v_q;
	assign result.data  = out_d_q;

	// --- checks
	// a short-data status may ride on the last item together with a valid pixel
	assign out_blocked = s1_busy && s1_emit && out_v_q && !result.ready;
	assign mid_pix     = result.valid && result.data.pixel_valid && !result.data.last_result;

	`PRU_ASSERT_NOW(a_stall_blocks_input, out_blocked, !feed.ready, "input taken while blocked")
	`PRU_ASSERT_NOW(a_valid_means_ok, mid_pix, result.data.status == ST_OK, "valid pixel with error")
	`PRU_ASSERT_NOW(a_invalid_is_zero, result.valid && !result.data.pixel_valid, result.data.pixel_byte == 8'd0, "nonzero byte")
	`PRU_ASSERT_NEXT(a_load_sets_valid, adv && s1_emit, out_v_q, "emitted item lost")

endmodule
